FILE: hw/rtl/apvp_pkg.sv
package apvp_pkg;

    typedef logic [23:0] color_t;
    typedef logic [17:0] dist_t;
    typedef logic [7:0]  idx_t;

    // Most entries the palette may hold; a full palette always reuses.
    localparam idx_t PALETTE_LIMIT = 8'd255;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_MERGE_THRESHOLD = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_SIZE       = 8'd1;

    localparam dist_t MERGE_THRESHOLD_RST = 18'd48;
    localparam idx_t  GRID_SIZE_RST       = 8'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    // One palette entry handed to the distance unit.
    typedef struct packed {
        logic valid;
        idx_t idx;
    } dist_req_t;

endpackage

FILE: hw/rtl/apvp_channels.sv
interface apvp_voxel_if;
    logic        valid;
    logic        ready;
    logic [23:0] voxel_color;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  pos_z;
    logic        new_model;

    modport source (output valid, voxel_color, pos_x, pos_y, pos_z, new_model, input ready);
    modport sink   (input valid, voxel_color, pos_x, pos_y, pos_z, new_model, output ready);
endinterface

interface apvp_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] voxel_word;
    logic [7:0]  palette_index;
    logic        entry_added;

    modport source (output valid, voxel_word, palette_index, entry_added, input ready);
    modport sink   (input valid, voxel_word, palette_index, entry_added, output ready);
endinterface

interface apvp_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  addr;
    logic [31:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

FILE: hw/rtl/apvp_palette_mem.sv
module apvp_palette_mem
    import apvp_pkg::*;
(
    input  logic   clk,
    input  logic   we,
    input  idx_t   waddr,
    input  color_t wdata,
    input  logic   re,
    input  idx_t   raddr,
    output color_t rdata
);

    color_t mem [256];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/apvp_dist_unit.sv
module apvp_dist_unit
    import apvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      clear,
    input  dist_req_t req,
    input  color_t    color,
    input  color_t    entry,
    output dist_t     best_dist,
    output idx_t      best_idx
);

    logic [7:0]  ad_r, ad_g, ad_b;
    logic [15:0] sq_r, sq_g, sq_b;
    dist_t       sum_sq;

    dist_t     dist_reg;
    dist_req_t req_reg;
    dist_t     best_dist_reg;
    idx_t      best_idx_reg;

    // Absolute channel differences, then squares summed.
    always_comb
    begin
        ad_r = (color[23:16] >= entry[23:16]) ? color[23:16] - entry[23:16]
                                              : entry[23:16] - color[23:16];
        ad_g = (color[15:8] >= entry[15:8]) ? color[15:8] - entry[15:8]
                                            : entry[15:8] - color[15:8];
        ad_b = (color[7:0] >= entry[7:0]) ? color[7:0] - entry[7:0]
                                          : entry[7:0] - color[7:0];
        sq_r   = ad_r * ad_r;
        sq_g   = ad_g * ad_g;
        sq_b   = ad_b * ad_b;
        sum_sq = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= '0;
        end
        else
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= sum_sq;
    end

    // Strict less-than keeps the lowest index on a tie.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
        end
        else if (clear)
        begin
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
        end
        else if (req_reg.valid && (dist_reg < best_dist_reg))
        begin
            best_dist_reg <= dist_reg;
            best_idx_reg  <= req_reg.idx;
        end
    end

    assign best_dist = best_dist_reg;
    assign best_idx  = best_idx_reg;

endmodule

FILE: hw/rtl/adaptive_palette_voxel_packer.sv
// Channel   Dir  Word carries
// --------  ---  ---------------------------------------------------------
// voxel     in   voxel_color, pos_x, pos_y, pos_z, new_model
// result    out  voxel_word, palette_index, entry_added
// cfg       in   addr (0 merge_threshold, 1 grid_size), data
//
// For each voxel, every stored entry is read in turn through the one read port
// of the palette memory and compared in the shared distance unit, followed by
// the end-of-scan check, pipeline drain and the decision. The next voxel is
// taken only once the block is back in idle, so a voxel holds the input
// channel until its decision is made.
// Reset clears the fill count, so the palette memory needs no clearing pass;
// new_model on a word zeroes that count the same way.
// A result waits in its output register; the next voxel is taken meanwhile,
// and only the decision step holds while that register is still full.
// cfg is always ready and is meant to be written only while the block idles.
module adaptive_palette_voxel_packer
    import apvp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    apvp_voxel_if.sink    voxel,
    apvp_result_if.source result,
    apvp_cfg_if.sink      cfg
);

    state_t state_reg, state_next;
    idx_t   count_reg, count_next;
    idx_t   scan_reg, scan_next;

    color_t color_reg;
    idx_t   x_reg, y_reg, z_reg;

    dist_t  thr_reg;
    idx_t   grid_reg;

    dist_req_t rd_req;
    dist_req_t rd_req_reg;
    logic      clear_best;
    logic      load_out;
    logic      reuse;
    idx_t      sel_idx;
    idx_t      grid_eff, z_clamp, z_flip;

    color_t entry;
    dist_t  best_dist;
    idx_t   best_idx;

    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    idx_t        out_idx_reg;
    logic        out_added_reg;

    // ---- configuration registers ----
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= MERGE_THRESHOLD_RST;
            grid_reg <= GRID_SIZE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                REG_MERGE_THRESHOLD: thr_reg  <= cfg.data[17:0];
                REG_GRID_SIZE:       grid_reg <= cfg.data[7:0];
                default:             ;
            endcase
        end
    end

    // ---- shared units ----
    apvp_palette_mem u_mem (
        .clk   (clk),
        .we    (load_out && !reuse),
        .waddr (count_reg),
        .wdata (color_reg),
        .re    (rd_req.valid),
        .raddr (rd_req.idx),
        .rdata (entry)
    );

    apvp_dist_unit u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear_best),
        .req       (rd_req_reg),
        .color     (color_reg),
        .entry     (entry),
        .best_dist (best_dist),
        .best_idx  (best_idx)
    );

    // Tag travels alongside the registered memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_req_reg <= '0;
        end
        else
        begin
            rd_req_reg <= rd_req;
        end
    end

    // ---- decision and packing ----
    always_comb
    begin
        reuse = ((count_reg != 8'd0) && (best_dist < thr_reg))
                || (count_reg >= PALETTE_LIMIT);
        sel_idx  = reuse ? best_idx : count_reg;
        grid_eff = (grid_reg == 8'd0) ? 8'd1 : grid_reg;
        z_clamp  = (z_reg >= grid_eff) ? grid_eff - 8'd1 : z_reg;
        z_flip   = grid_eff - 8'd1 - z_clamp;
    end

    // ---- sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        voxel.ready = 1'b0;
        rd_req      = '0;
        clear_best  = 1'b0;
        load_out    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                voxel.ready = 1'b1;
                if (voxel.valid)
                begin
                    clear_best = 1'b1;
                    scan_next  = '0;
                    if (voxel.new_model)
                    begin
                        count_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Issue one entry read a cycle until every stored entry is out.
                if (scan_reg == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_req.valid = 1'b1;
                    rd_req.idx   = scan_reg;
                    scan_next    = scan_reg + 8'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || result.ready)
                begin
                    load_out = 1'b1;
                    if (!reuse)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Latch the voxel on accept.
    always_ff @(posedge clk)
    begin
        if (voxel.valid && voxel.ready)
        begin
            color_reg <= voxel.voxel_color;
            x_reg     <= voxel.pos_x;
            y_reg     <= voxel.pos_y;
            z_reg     <= voxel.pos_z;
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_word_reg  <= {sel_idx + 8'd1, y_reg, z_flip, x_reg};
            out_idx_reg   <= sel_idx;
            out_added_reg <= !reuse;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.voxel_word    = out_word_reg;
    assign result.palette_index = out_idx_reg;
    assign result.entry_added   = out_added_reg;

    // ---- checks ----
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PALETTE_LIMIT)
        else $error("palette fill count beyond limit");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_reg <= count_reg))
        else $error("scan index past fill count");

    a_word_index: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.voxel_word[31:24] == result.palette_index + 8'd1))
        else $error("voxel word index byte disagrees with palette index");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !reuse) |=> (count_reg == $past(count_reg) + 8'd1))
        else $error("append did not advance fill count");

endmodule
